[design/oda_pkg.sv]
// ----------------------------------------------------------------------------
// oda_pkg
// Shared types and the opcode table of the opcode decode and address
// generator.
// ----------------------------------------------------------------------------
package oda_pkg;

    typedef enum logic {
        OP_START = 1'b0,
        OP_READ  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        K_REQ   = 2'd0,
        K_DONE  = 2'd1,
        K_BAD   = 2'd2,
        K_UNEXP = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        MD_IMPL = 4'd0,
        MD_IMM  = 4'd1,
        MD_ZP   = 4'd2,
        MD_ZPI  = 4'd3,
        MD_ABS  = 4'd4,
        MD_ABX  = 4'd5,
        MD_ABY  = 4'd6,
        MD_IND  = 4'd7,
        MD_IZX  = 4'd8,
        MD_IZY  = 4'd9,
        MD_REL  = 4'd10
    } t_mode;

    typedef enum logic [4:0] {
        MN_LDA = 5'd0,  MN_LDX = 5'd1,  MN_LDY = 5'd2,  MN_STA = 5'd3,
        MN_STX = 5'd4,  MN_STY = 5'd5,  MN_DEX = 5'd6,  MN_INX = 5'd7,
        MN_DEY = 5'd8,  MN_INY = 5'd9,  MN_INC = 5'd10, MN_DEC = 5'd11,
        MN_PHA = 5'd12, MN_PLA = 5'd13, MN_CMP = 5'd14, MN_CPX = 5'd15,
        MN_CPY = 5'd16, MN_BNE = 5'd17, MN_BEQ = 5'd18, MN_JSR = 5'd19,
        MN_RTS = 5'd20, MN_JMP = 5'd21, MN_CLC = 5'd22, MN_SEC = 5'd23,
        MN_AND = 5'd24, MN_ORA = 5'd25, MN_EOR = 5'd26, MN_BIT = 5'd27
    } t_mnem;

    typedef enum logic [1:0] {
        ST_BYTE0 = 2'd0,
        ST_BYTE1 = 2'd1,
        ST_BYTE2 = 2'd2,
        ST_BYTE3 = 2'd3
    } t_step;

    typedef struct packed {
        logic       ok;
        t_mnem      mn;
        t_mode      md;
        logic [2:0] cy;
    } t_entry;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] address;
        logic [15:0] rel_offset;
        logic        page_crossed;
        logic [15:0] next_pc;
        t_mnem       mnemonic;
        t_mode       mode;
        logic [2:0]  cycles;
    } t_result;

    function automatic t_entry decode_opcode(input logic [7:0] op);
        t_entry e;
        e = '{1'b0, MN_LDA, MD_IMPL, 3'd0};
        case (op)
            8'hA9: e = '{1'b1, MN_LDA, MD_IMM, 3'd2};
            8'hA5: e = '{1'b1, MN_LDA, MD_ZP,  3'd3};
            8'hB5: e = '{1'b1, MN_LDA, MD_ZPI, 3'd4};
            8'hAD: e = '{1'b1, MN_LDA, MD_ABS, 3'd4};
            8'hBD: e = '{1'b1, MN_LDA, MD_ABX, 3'd4};
            8'hB9: e = '{1'b1, MN_LDA, MD_ABY, 3'd4};
            8'hA1: e = '{1'b1, MN_LDA, MD_IZX, 3'd6};
            8'hB1: e = '{1'b1, MN_LDA, MD_IZY, 3'd5};
            8'hA2: e = '{1'b1, MN_LDX, MD_IMM, 3'd2};
            8'hA6: e = '{1'b1, MN_LDX, MD_ZP,  3'd3};
            8'hB6: e = '{1'b1, MN_LDX, MD_ZPI, 3'd4};
            8'hAE: e = '{1'b1, MN_LDX, MD_ABS, 3'd4};
            8'hBE: e = '{1'b1, MN_LDX, MD_ABY, 3'd4};
            8'hA0: e = '{1'b1, MN_LDY, MD_IMM, 3'd2};
            8'hA4: e = '{1'b1, MN_LDY, MD_ZP,  3'd3};
            8'hB4: e = '{1'b1, MN_LDY, MD_ZPI, 3'd4};
            8'hAC: e = '{1'b1, MN_LDY, MD_ABS, 3'd4};
            8'hBC: e = '{1'b1, MN_LDY, MD_ABX, 3'd4};
            8'h85: e = '{1'b1, MN_STA, MD_ZP,  3'd3};
            8'h95: e = '{1'b1, MN_STA, MD_ZPI, 3'd4};
            8'h8D: e = '{1'b1, MN_STA, MD_ABS, 3'd4};
            8'h9D: e = '{1'b1, MN_STA, MD_ABX, 3'd5};
            8'h99: e = '{1'b1, MN_STA, MD_ABY, 3'd5};
            8'h81: e = '{1'b1, MN_STA, MD_IZX, 3'd6};
            8'h91: e = '{1'b1, MN_STA, MD_IZY, 3'd6};
            8'h86: e = '{1'b1, MN_STX, MD_ZP,  3'd3};
            8'h96: e = '{1'b1, MN_STX, MD_ZPI, 3'd4};
            8'h8E: e = '{1'b1, MN_STX, MD_ABS, 3'd4};
            8'h84: e = '{1'b1, MN_STY, MD_ZP,  3'd3};
            8'h94: e = '{1'b1, MN_STY, MD_ZPI, 3'd4};
            8'h8C: e = '{1'b1, MN_STY, MD_ABS, 3'd4};
            8'hCA: e = '{1'b1, MN_DEX, MD_IMPL, 3'd2};
            8'hE8: e = '{1'b1, MN_INX, MD_IMPL, 3'd2};
            8'h88: e = '{1'b1, MN_DEY, MD_IMPL, 3'd2};
            8'hC8: e = '{1'b1, MN_INY, MD_IMPL, 3'd2};
            8'hE6: e = '{1'b1, MN_INC, MD_ZP,  3'd5};
            8'hF6: e = '{1'b1, MN_INC, MD_ZPI, 3'd6};
            8'hEE: e = '{1'b1, MN_INC, MD_ABS, 3'd6};
            8'hFE: e = '{1'b1, MN_INC, MD_ABX, 3'd7};
            8'hC6: e = '{1'b1, MN_DEC, MD_ZP,  3'd5};
            8'hD6: e = '{1'b1, MN_DEC, MD_ZPI, 3'd6};
            8'hCE: e = '{1'b1, MN_DEC, MD_ABS, 3'd6};
            8'hDE: e = '{1'b1, MN_DEC, MD_ABX, 3'd7};
            8'h48: e = '{1'b1, MN_PHA, MD_IMPL, 3'd3};
            8'h68: e = '{1'b1, MN_PLA, MD_IMPL, 3'd4};
            8'hC9: e = '{1'b1, MN_CMP, MD_IMM, 3'd2};
            8'hC5: e = '{1'b1, MN_CMP, MD_ZP,  3'd3};
            8'hD5: e = '{1'b1, MN_CMP, MD_ZPI, 3'd4};
            8'hCD: e = '{1'b1, MN_CMP, MD_ABS, 3'd4};
            8'hDD: e = '{1'b1, MN_CMP, MD_ABX, 3'd4};
            8'hD9: e = '{1'b1, MN_CMP, MD_ABY, 3'd4};
            8'hC1: e = '{1'b1, MN_CMP, MD_IZX, 3'd6};
            8'hD1: e = '{1'b1, MN_CMP, MD_IZY, 3'd5};
            8'hE0: e = '{1'b1, MN_CPX, MD_IMM, 3'd2};
            8'hE4: e = '{1'b1, MN_CPX, MD_ZP,  3'd3};
            8'hEC: e = '{1'b1, MN_CPX, MD_ABS, 3'd4};
            8'hC0: e = '{1'b1, MN_CPY, MD_IMM, 3'd2};
            8'hC4: e = '{1'b1, MN_CPY, MD_ZP,  3'd3};
            8'hCC: e = '{1'b1, MN_CPY, MD_ABS, 3'd4};
            8'hD0: e = '{1'b1, MN_BNE, MD_REL, 3'd2};
            8'hF0: e = '{1'b1, MN_BEQ, MD_REL, 3'd2};
            8'h20: e = '{1'b1, MN_JSR, MD_ABS, 3'd6};
            8'h60: e = '{1'b1, MN_RTS, MD_IMPL, 3'd6};
            8'h4C: e = '{1'b1, MN_JMP, MD_ABS, 3'd3};
            8'h6C: e = '{1'b1, MN_JMP, MD_IND, 3'd5};
            8'h18: e = '{1'b1, MN_CLC, MD_IMPL, 3'd2};
            8'h38: e = '{1'b1, MN_SEC, MD_IMPL, 3'd2};
            8'h29: e = '{1'b1, MN_AND, MD_IMM, 3'd2};
            8'h25: e = '{1'b1, MN_AND, MD_ZP,  3'd3};
            8'h35: e = '{1'b1, MN_AND, MD_ZPI, 3'd4};
            8'h2D: e = '{1'b1, MN_AND, MD_ABS, 3'd4};
            8'h3D: e = '{1'b1, MN_AND, MD_ABX, 3'd4};
            8'h39: e = '{1'b1, MN_AND, MD_ABY, 3'd4};
            8'h21: e = '{1'b1, MN_AND, MD_IZX, 3'd6};
            8'h31: e = '{1'b1, MN_AND, MD_IZY, 3'd5};
            8'h09: e = '{1'b1, MN_ORA, MD_IMM, 3'd2};
            8'h05: e = '{1'b1, MN_ORA, MD_ZP,  3'd3};
            8'h15: e = '{1'b1, MN_ORA, MD_ZPI, 3'd4};
            8'h0D: e = '{1'b1, MN_ORA, MD_ABS, 3'd4};
            8'h1D: e = '{1'b1, MN_ORA, MD_ABX, 3'd4};
            8'h19: e = '{1'b1, MN_ORA, MD_ABY, 3'd4};
            8'h01: e = '{1'b1, MN_ORA, MD_IZX, 3'd6};
            8'h11: e = '{1'b1, MN_ORA, MD_IZY, 3'd5};
            8'h49: e = '{1'b1, MN_EOR, MD_IMM, 3'd2};
            8'h45: e = '{1'b1, MN_EOR, MD_ZP,  3'd3};
            8'h55: e = '{1'b1, MN_EOR, MD_ZPI, 3'd4};
            8'h4D: e = '{1'b1, MN_EOR, MD_ABS, 3'd4};
            8'h5D: e = '{1'b1, MN_EOR, MD_ABX, 3'd4};
            8'h59: e = '{1'b1, MN_EOR, MD_ABY, 3'd4};
            8'h41: e = '{1'b1, MN_EOR, MD_IZX, 3'd6};
            8'h51: e = '{1'b1, MN_EOR, MD_IZY, 3'd5};
            8'h24: e = '{1'b1, MN_BIT, MD_ZP,  3'd3};
            8'h2C: e = '{1'b1, MN_BIT, MD_ABS, 3'd4};
            default: e = '{1'b0, MN_LDA, MD_IMPL, 3'd0};
        endcase
        return e;
    endfunction

endpackage

[design/oda_step.sv]
// ----------------------------------------------------------------------------
// oda_step
// Sequence state and result logic: decodes a start transaction, walks the
// operand reads of the addressing mode and forms each result.
// ----------------------------------------------------------------------------
module oda_step (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic              i_operation,
    input  logic [7:0]        i_opcode,
    input  logic [15:0]       i_pc,
    input  logic [7:0]        i_index_x,
    input  logic [7:0]        i_index_y,
    input  logic [7:0]        i_read_data,
    output oda_pkg::t_result  o_result
);
    import oda_pkg::*;

    logic        r_busy, n_busy;
    t_step       r_step, n_step;
    t_mode       r_mode, n_mode;
    t_mnem       r_mn, n_mn;
    logic [2:0]  r_cy, n_cy;
    logic [15:0] r_pc, n_pc;
    logic [7:0]  r_x, n_x;
    logic [7:0]  r_y, n_y;
    logic [7:0]  r_op_lo, n_op_lo;
    logic [7:0]  r_op_hi, n_op_hi;
    logic [7:0]  r_tgt_lo, n_tgt_lo;

    t_entry      entry;
    logic [15:0] pc_p1, pc_p2;
    logic [7:0]  zp_idx, abs_idx, zb_first, zb_next;
    logic [15:0] abs_base, abs_ea, izy_base, izy_ea, off_ext;

    assign entry    = decode_opcode(i_opcode);
    assign pc_p1    = r_pc + 16'd1;
    assign pc_p2    = r_pc + 16'd2;
    assign zp_idx   = (r_mn == MN_LDX || r_mn == MN_STX) ? r_y : r_x;
    assign abs_idx  = (r_mode == MD_ABX) ? r_x : r_y;
    assign zb_first = (r_mode == MD_IZX) ? i_read_data + r_x : i_read_data;
    assign zb_next  = ((r_mode == MD_IZX) ? r_op_lo + r_x : r_op_lo) + 8'd1;
    assign abs_base = {i_read_data, r_op_lo};
    assign abs_ea   = abs_base + {8'd0, abs_idx};
    assign izy_base = {i_read_data, r_tgt_lo};
    assign izy_ea   = izy_base + {8'd0, r_y};
    assign off_ext  = {{8{i_read_data[7]}}, i_read_data};

    always_comb begin
        n_busy   = r_busy;
        n_step   = r_step;
        n_mode   = r_mode;
        n_mn     = r_mn;
        n_cy     = r_cy;
        n_pc     = r_pc;
        n_x      = r_x;
        n_y      = r_y;
        n_op_lo  = r_op_lo;
        n_op_hi  = r_op_hi;
        n_tgt_lo = r_tgt_lo;
        if (i_operation == OP_START) begin
            n_busy = 1'b0;
            n_step = ST_BYTE0;
            if (entry.ok) begin
                n_mode = entry.md;
                n_mn   = entry.mn;
                n_cy   = entry.cy;
                n_pc   = i_pc;
                n_x    = i_index_x;
                n_y    = i_index_y;
                n_busy = (entry.md != MD_IMPL) && (entry.md != MD_IMM);
            end
        end else if (r_busy) begin
            n_busy = 1'b0;
            n_step = ST_BYTE0;
            case (r_mode)
                MD_ABS, MD_ABX, MD_ABY, MD_IND: begin
                    case (r_step)
                        ST_BYTE0: begin
                            n_op_lo = i_read_data;
                            n_busy  = 1'b1;
                            n_step  = ST_BYTE1;
                        end
                        ST_BYTE1: begin
                            n_op_hi = i_read_data;
                            if (r_mode == MD_IND) begin
                                n_busy = 1'b1;
                                n_step = ST_BYTE2;
                            end
                        end
                        ST_BYTE2: begin
                            if (r_mode == MD_IND) begin
                                n_tgt_lo = i_read_data;
                                n_busy   = 1'b1;
                                n_step   = ST_BYTE3;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                MD_IZX, MD_IZY: begin
                    case (r_step)
                        ST_BYTE0: begin
                            n_op_lo = i_read_data;
                            n_busy  = 1'b1;
                            n_step  = ST_BYTE1;
                        end
                        ST_BYTE1: begin
                            n_tgt_lo = i_read_data;
                            n_busy   = 1'b1;
                            n_step   = ST_BYTE2;
                        end
                        default: begin
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_result = '{K_UNEXP, 16'd0, 16'd0, 1'b0, 16'd0, MN_LDA, MD_IMPL, 3'd0};
        if (i_operation == OP_START) begin
            if (!entry.ok) begin
                o_result.kind = K_BAD;
            end else begin
                o_result.mnemonic = entry.mn;
                o_result.mode     = entry.md;
                o_result.cycles   = entry.cy;
                if (entry.md == MD_IMPL) begin
                    o_result.kind    = K_DONE;
                    o_result.next_pc = i_pc;
                end else if (entry.md == MD_IMM) begin
                    o_result.kind    = K_DONE;
                    o_result.address = i_pc;
                    o_result.next_pc = i_pc + 16'd1;
                end else begin
                    o_result.kind    = K_REQ;
                    o_result.address = i_pc;
                end
            end
        end else if (r_busy) begin
            o_result.mnemonic = r_mn;
            o_result.mode     = r_mode;
            o_result.cycles   = r_cy;
            case (r_mode)
                MD_ZP: begin
                    o_result.kind    = K_DONE;
                    o_result.address = {8'd0, i_read_data};
                    o_result.next_pc = pc_p1;
                end
                MD_ZPI: begin
                    o_result.kind    = K_DONE;
                    o_result.address = {8'd0, i_read_data + zp_idx};
                    o_result.next_pc = pc_p1;
                end
                MD_REL: begin
                    o_result.kind       = K_DONE;
                    o_result.rel_offset = off_ext;
                    o_result.next_pc    = pc_p1;
                end
                MD_ABS, MD_ABX, MD_ABY, MD_IND: begin
                    case (r_step)
                        ST_BYTE0: begin
                            o_result.kind    = K_REQ;
                            o_result.address = pc_p1;
                        end
                        ST_BYTE1: begin
                            if (r_mode == MD_IND) begin
                                o_result.kind    = K_REQ;
                                o_result.address = abs_base;
                            end else begin
                                o_result.kind    = K_DONE;
                                o_result.next_pc = pc_p2;
                                if (r_mode == MD_ABS) begin
                                    o_result.address = abs_base;
                                end else begin
                                    o_result.address      = abs_ea;
                                    o_result.page_crossed = abs_ea[15:8] != abs_base[15:8];
                                end
                            end
                        end
                        ST_BYTE2: begin
                            if (r_mode == MD_IND) begin
                                o_result.kind    = K_REQ;
                                o_result.address = {r_op_hi, r_op_lo + 8'd1};
                            end
                        end
                        ST_BYTE3: begin
                            if (r_mode == MD_IND) begin
                                o_result.kind    = K_DONE;
                                o_result.address = {i_read_data, r_tgt_lo};
                                o_result.next_pc = pc_p2;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                MD_IZX, MD_IZY: begin
                    case (r_step)
                        ST_BYTE0: begin
                            o_result.kind    = K_REQ;
                            o_result.address = {8'd0, zb_first};
                        end
                        ST_BYTE1: begin
                            o_result.kind    = K_REQ;
                            o_result.address = {8'd0, zb_next};
                        end
                        ST_BYTE2: begin
                            o_result.kind    = K_DONE;
                            o_result.next_pc = pc_p1;
                            if (r_mode == MD_IZX) begin
                                o_result.address = izy_base;
                            end else begin
                                o_result.address      = izy_ea;
                                o_result.page_crossed = izy_ea[15:8] != izy_base[15:8];
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                default: begin
                end
            endcase
            // A read that ends no sequence drops the sequence.
            if (o_result.kind == K_UNEXP) begin
                o_result.mnemonic = MN_LDA;
                o_result.mode     = MD_IMPL;
                o_result.cycles   = 3'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= ST_BYTE0;
        end else if (i_accept) begin
            r_busy <= n_busy;
            r_step <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_mode   <= n_mode;
            r_mn     <= n_mn;
            r_cy     <= n_cy;
            r_pc     <= n_pc;
            r_x      <= n_x;
            r_y      <= n_y;
            r_op_lo  <= n_op_lo;
            r_op_hi  <= n_op_hi;
            r_tgt_lo <= n_tgt_lo;
        end
    end

`ifndef NO_ASSERTIONS
    a_idle_step_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> r_step == ST_BYTE0)
        else $error("step is nonzero while no sequence runs");
    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_operation == OP_START && !entry.ok) |=> !r_busy)
        else $error("invalid opcode left a sequence running");
    a_ind_only_step3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_step == ST_BYTE3) |-> r_mode == MD_IND)
        else $error("fourth operand read outside indirect mode");
`endif

endmodule

[design/opcode_decode_address_generator.sv]
// ----------------------------------------------------------------------------
// opcode_decode_address_generator
// Opcode decoder and addressing-mode address generator for a 6502 core.
// ----------------------------------------------------------------------------
// A start transaction (operation 0) carries an opcode, the PC of the byte
// after it and the X and Y registers. The block decodes the opcode and
// answers with a read request, an immediate done result, or an invalid
// opcode result. Each read request is answered by a read-data transaction
// (operation 1); the final one yields the effective address, the branch
// offset, the page-cross flag and the next PC. Every input transaction
// gives exactly one result transaction.
// The result is registered: it appears in the output register on the
// clock after the input transaction. One transaction per cycle is accepted
// while the output register is empty or being drained, so throughput is one
// per cycle; it is set by the single decode/add stage before that register.
// When the receiver stalls with a result held, o_stall rises and no new
// input is taken. Reset empties the output register and ends any sequence.
// ----------------------------------------------------------------------------
module opcode_decode_address_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_operation,
    input  logic [7:0]  i_opcode,
    input  logic [15:0] i_pc,
    input  logic [7:0]  i_index_x,
    input  logic [7:0]  i_index_y,
    input  logic [7:0]  i_read_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [15:0] o_address,
    output logic [15:0] o_rel_offset,
    output logic        o_page_crossed,
    output logic [15:0] o_next_pc,
    output logic [4:0]  o_mnemonic,
    output logic [3:0]  o_mode,
    output logic [2:0]  o_base_cycles
);
    import oda_pkg::*;

    logic    in_accept;
    t_result result;
    logic    r_valid;
    t_result r_res;

    assign o_stall   = r_valid && i_stall;
    assign in_accept = i_valid && !o_stall;

    oda_step u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_operation (i_operation),
        .i_opcode    (i_opcode),
        .i_pc        (i_pc),
        .i_index_x   (i_index_x),
        .i_index_y   (i_index_y),
        .i_read_data (i_read_data),
        .o_result    (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (in_accept) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_res <= result;
        end
    end

    assign o_valid        = r_valid;
    assign o_kind         = r_res.kind;
    assign o_address      = r_res.address;
    assign o_rel_offset   = r_res.rel_offset;
    assign o_page_crossed = r_res.page_crossed;
    assign o_next_pc      = r_res.next_pc;
    assign o_mnemonic     = r_res.mnemonic;
    assign o_mode         = r_res.mode;
    assign o_base_cycles  = r_res.cycles;

`ifndef NO_ASSERTIONS
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_valid)
        else $error("accepted transaction produced no result");
    a_drain_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !in_accept) |=> !o_valid)
        else $error("delivered result was repeated");
    a_error_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_kind == K_BAD || o_kind == K_UNEXP)) |->
        (o_address == 16'd0 && o_mnemonic == 5'd0 && o_mode == 4'd0 &&
         o_base_cycles == 3'd0 && o_next_pc == 16'd0))
        else $error("error result carries nonzero fields");
    a_request_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == K_REQ) |->
        (o_rel_offset == 16'd0 && o_next_pc == 16'd0 && !o_page_crossed))
        else $error("read request carries done fields");
`endif

endmodule
